// ===== design/pip_pkg.sv =====
`default_nettype none

package pip_pkg;

  // Store and coordinate sizing
  localparam int MAX_VERTICES  = 64;
  localparam int COORD_BITS    = 20;
  localparam int IDX_W         = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W         = $clog2(MAX_VERTICES + 1);
  localparam int ACTION_W      = 2;
  localparam int COUNT_FIELD_W = 7;
  // Signed differences carry one extra bit, products twice that
  localparam int DIFF_W        = COORD_BITS + 1;
  localparam int PROD_W        = 2 * DIFF_W;
  localparam int MIN_VERTICES  = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEST   = 2'd2
  } pip_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } pip_state_e;

  // Query token that walks the cell chain
  typedef struct packed {
    logic                  vld;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [COORD_BITS-1:0] prev_x;
    logic [COORD_BITS-1:0] prev_y;
    logic                  parity;
  } pip_token_t;

  // Vertex write broadcast into the chain
  typedef struct packed {
    logic                  clr;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } pip_wr_t;

endpackage

`default_nettype wire

// ===== design/pip_req_if.sv =====
`default_nettype none

interface pip_req_if import pip_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;

  modport source (output valid, action, point_x, point_y, input ready);
  modport sink   (input valid, action, point_x, point_y, output ready);
endinterface

`default_nettype wire

// ===== design/pip_res_if.sv =====
`default_nettype none

interface pip_res_if import pip_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     inside_res;
  logic [COUNT_FIELD_W-1:0] vertex_count;
  logic                     dropped;

  modport source (output valid, inside_res, vertex_count, dropped, input ready);
  modport sink   (input valid, inside_res, vertex_count, dropped, output ready);
endinterface

`default_nettype wire

// ===== design/pip_cell.sv =====
`default_nettype none

// One vertex of the polygon and the edge that ends at it.
// Stage 1 sorts the edge ends and forms differences, stage 2 does the
// cross-product sign test and folds the hit into the token parity.
module pip_cell import pip_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  pip_wr_t    wr_i,
  input  pip_token_t tok_i,
  output pip_token_t tok_o
);

  logic [COORD_BITS-1:0] vx_q, vy_q;
  logic                  act_q;

  pip_token_t        tok1_q;
  logic              act1_q;
  logic              skip_q, left_q;
  logic signed [DIFF_W-1:0] sx_q, ex_q;
  logic [COORD_BITS-1:0]    sy_q, ey_q;
  pip_token_t        tok2_q;

  logic [COORD_BITS-1:0] far_x, near_x, bx, by, tx, ty;
  logic                  c_low, horiz, ypass, skip_d, left_d;
  logic signed [DIFF_W-1:0] sx_d, ex_d;
  logic signed [DIFF_W-1:0] sy_s, ey_s;
  logic signed [PROD_W-1:0] lhs, rhs;
  logic                     hit;

  // vertex storage and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (wr_i.clr) begin
      act_q <= 1'b0;
    end else if (wr_en_i) begin
      act_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      vx_q <= wr_i.x;
      vy_q <= wr_i.y;
    end
  end

  // stage 1: orient the edge from its lower-y end
  always_comb begin
    horiz  = (tok_i.prev_y == vy_q);
    far_x  = (vx_q < tok_i.prev_x) ? tok_i.prev_x : vx_q;
    near_x = (vx_q < tok_i.prev_x) ? vx_q : tok_i.prev_x;
    c_low  = (vy_q < tok_i.prev_y);
    bx     = c_low ? vx_q : tok_i.prev_x;
    by     = c_low ? vy_q : tok_i.prev_y;
    tx     = c_low ? tok_i.prev_x : vx_q;
    ty     = c_low ? tok_i.prev_y : vy_q;
    ypass  = (tok_i.py >= by) && (tok_i.py < ty);
    skip_d = !act_q || horiz || (tok_i.px >= far_x) || !ypass;
    left_d = (tok_i.px < near_x);
    sx_d   = $signed({1'b0, tok_i.px}) - $signed({1'b0, bx});
    ex_d   = $signed({1'b0, tx}) - $signed({1'b0, bx});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok1_q <= '0;
    end else begin
      tok1_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    act1_q <= act_q;
    skip_q <= skip_d;
    left_q <= left_d;
    sx_q   <= sx_d;
    ex_q   <= ex_d;
    sy_q   <= tok_i.py - by;
    ey_q   <= ty - by;
  end

  // stage 2: sign of the cross product
  always_comb begin
    sy_s = $signed({1'b0, sy_q});
    ey_s = $signed({1'b0, ey_q});
    lhs  = sx_q * ey_s;
    rhs  = sy_s * ex_q;
    hit  = !skip_q && (left_q || (lhs < rhs));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok2_q <= '0;
    end else begin
      tok2_q.vld    <= tok1_q.vld;
      tok2_q.px     <= tok1_q.px;
      tok2_q.py     <= tok1_q.py;
      tok2_q.prev_x <= act1_q ? vx_q : tok1_q.prev_x;
      tok2_q.prev_y <= act1_q ? vy_q : tok1_q.prev_y;
      tok2_q.parity <= tok1_q.parity ^ hit;
    end
  end

  assign tok_o = tok2_q;

endmodule

`default_nettype wire

// ===== design/point_in_polygon_test_unit.sv =====
`default_nettype none

// Channel  | Dir | Payload                              | Handshake
// req_i    | in  | action, point_x, point_y             | valid/ready
// res_o    | out | inside_res, vertex_count, dropped    | valid/ready
//
// Clear, append and unused actions answer in the cycle after acceptance.
// A test is registered into a chain of MAX_VERTICES cells, walks it, and
// answers once the token leaves the last cell and the output register is free.
// One request is worked at a time; a new one is taken only when the output
// register is empty or is read in that cycle, and never while a test is in flight.
// Reset (rst_ni, asynchronous, active low) empties the polygon and box.
module point_in_polygon_test_unit import pip_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  pip_req_if.sink  req_i,
  pip_res_if.source res_o
);

  pip_state_e state_q, state_d;

  logic [CNT_W-1:0]      count_q, count_d;
  logic [COORD_BITS-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic [COORD_BITS-1:0] last_x_q, last_y_q;
  logic                  ok_q;
  logic                  res_q;

  logic                     out_vld_q;
  logic                     out_inside_q;
  logic [COUNT_FIELD_W-1:0] out_count_q;
  logic                     out_drop_q;

  pip_token_t inject_q;
  pip_token_t chain [MAX_VERTICES+1];
  logic [MAX_VERTICES-1:0] wr_en;
  pip_wr_t                 wr;

  logic accept, full, clear_go, append_go, test_go, other_go, load_res, box_in;
  pip_action_e act;

  // request decode
  always_comb begin
    act       = pip_action_e'(req_i.action);
    accept    = req_i.valid && req_i.ready;
    full      = (count_q >= CNT_W'(MAX_VERTICES));
    clear_go  = 1'b0;
    append_go = 1'b0;
    test_go   = 1'b0;
    if (accept) begin
      case (act)
        ACT_CLEAR:  clear_go  = 1'b1;
        ACT_APPEND: append_go = !full;
        ACT_TEST:   test_go   = 1'b1;
        default:    ;
      endcase
    end
    other_go = accept && !test_go;
    box_in   = (count_q >= CNT_W'(MIN_VERTICES)) &&
               (req_i.point_x >= min_x_q) && (req_i.point_x <= max_x_q) &&
               (req_i.point_y >= min_y_q) && (req_i.point_y <= max_y_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (test_go) state_d = ST_RUN;
      ST_RUN:  if (chain[MAX_VERTICES].vld) state_d = ST_DONE;
      ST_DONE: if (!out_vld_q || res_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_i.ready = 1'b0;
    load_res    = 1'b0;
    case (state_q)
      ST_IDLE: req_i.ready = !out_vld_q || res_o.ready;
      ST_DONE: load_res    = !out_vld_q || res_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // polygon count and bounding box
  always_comb begin
    count_d = count_q;
    if (clear_go) begin
      count_d = '0;
    end else if (append_go) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_x_q <= '1;
      min_y_q <= '1;
      max_x_q <= '0;
      max_y_q <= '0;
    end else begin
      count_q <= count_d;
      if (clear_go) begin
        min_x_q <= '1;
        min_y_q <= '1;
        max_x_q <= '0;
        max_y_q <= '0;
      end else if (append_go) begin
        if (req_i.point_x < min_x_q) min_x_q <= req_i.point_x;
        if (req_i.point_x > max_x_q) max_x_q <= req_i.point_x;
        if (req_i.point_y < min_y_q) min_y_q <= req_i.point_y;
        if (req_i.point_y > max_y_q) max_y_q <= req_i.point_y;
      end
    end
  end

  // last vertex closes the polygon; box check rides along with the query
  always_ff @(posedge clk_i) begin
    if (append_go) begin
      last_x_q <= req_i.point_x;
      last_y_q <= req_i.point_y;
    end
    if (test_go) begin
      ok_q <= box_in;
    end
    if (chain[MAX_VERTICES].vld) begin
      res_q <= chain[MAX_VERTICES].parity;
    end
  end

  // query injection
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inject_q <= '0;
    end else begin
      inject_q.vld    <= test_go;
      inject_q.px     <= req_i.point_x;
      inject_q.py     <= req_i.point_y;
      inject_q.prev_x <= last_x_q;
      inject_q.prev_y <= last_y_q;
      inject_q.parity <= 1'b0;
    end
  end

  // vertex write select
  always_comb begin
    wr.clr = clear_go;
    wr.x   = req_i.point_x;
    wr.y   = req_i.point_y;
    for (int k = 0; k < MAX_VERTICES; k++) begin
      wr_en[k] = append_go && (count_q[IDX_W-1:0] == IDX_W'(k));
    end
  end

  assign chain[0] = inject_q;

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    pip_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_en_i (wr_en[g]),
      .wr_i    (wr),
      .tok_i   (chain[g]),
      .tok_o   (chain[g+1])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (other_go || load_res) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (other_go) begin
      out_inside_q <= 1'b0;
      out_count_q  <= COUNT_FIELD_W'(count_d);
      out_drop_q   <= (act == ACT_APPEND) && full;
    end else if (load_res) begin
      out_inside_q <= res_q && ok_q;
      out_count_q  <= COUNT_FIELD_W'(count_q);
      out_drop_q   <= 1'b0;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.inside_res   = out_inside_q;
  assign res_o.vertex_count = out_count_q;
  assign res_o.dropped      = out_drop_q;

  // checks
  a_chain_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[MAX_VERTICES].vld |-> state_q == ST_RUN)
    else $error("query token left chain outside a test");

  a_test_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    test_go |=> state_q == ST_RUN && inject_q.vld)
    else $error("accepted test did not enter the chain");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond store size");

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_drop_q |-> count_q == CNT_W'(MAX_VERTICES))
    else $error("append dropped with room left");

endmodule

`default_nettype wire

// ===== verif/tb_point_in_polygon_test_unit.sv =====
`default_nettype none

module tb_point_in_polygon_test_unit;
  import pip_pkg::*;

  // Unused action code, taken without effect
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
  localparam logic [COORD_BITS-1:0] COORD_MID = COORD_MAX >> 1;

  localparam int RANDOM_ITEMS   = 800;
  localparam int DIRECTED_ITEMS = 25;
  localparam int MAX_GAP        = 6;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AT_A      = 60;
  localparam int HOLD_AT_B      = 500;
  localparam int TAIL_CYCLES    = 2 * MAX_VERTICES + 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRINT_LIMIT    = 50;

  typedef struct {
    logic [ACTION_W-1:0]   action;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    bit                    drain;  // hold back until all results are in
  } pip_cmd_t;

  typedef struct {
    logic                     in_poly;
    logic [COUNT_FIELD_W-1:0] count;
    logic                     dropped;
  } pip_outcome_t;

  logic clk_i;
  logic rst_ni;

  pip_req_if req_if ();
  pip_res_if res_if ();

  point_in_polygon_test_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // Requests waiting to be driven, and outcomes waiting to be seen
  pip_cmd_t     cmd_queue[$];
  pip_outcome_t outcome_queue[$];

  int n_queued;
  int n_planned;
  int n_accepted;
  int n_results;
  int mismatches;

  // Polygon as the generator plans it, used to aim test points
  logic [COORD_BITS-1:0] plan_xs[$];
  logic [COORD_BITS-1:0] plan_ys[$];

  // Predicted polygon store and bounding box
  logic [COORD_BITS-1:0] poly_xs [MAX_VERTICES];
  logic [COORD_BITS-1:0] poly_ys [MAX_VERTICES];
  int                    poly_count;
  logic [COORD_BITS-1:0] bb_min_x, bb_max_x, bb_min_y, bb_max_y;

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------

  function automatic void clear_geometry();
    poly_count = 0;
    bb_min_x   = COORD_MAX;
    bb_min_y   = COORD_MAX;
    bb_max_x   = '0;
    bb_max_y   = '0;
  endfunction

  // Ray toward +x from (px,py) against edge (ax,ay)-(cx,cy)
  function automatic bit crosses_edge(longint px, longint py, longint ax, longint ay,
                                      longint cx, longint cy);
    longint far_x, near_x, bx, by, ex, ey, sx, sy;
    if (ay == cy) return 1'b0;
    far_x  = (cx < ax) ? ax : cx;
    near_x = (cx < ax) ? cx : ax;
    if (px >= far_x) return 1'b0;
    if (cy < ay) begin
      bx = cx; by = cy; ex = ax - cx; ey = ay - cy;
    end else begin
      bx = ax; by = ay; ex = cx - ax; ey = cy - ay;
    end
    // half-open y span: lower end in, upper end out
    if (py < by || py >= by + ey) return 1'b0;
    if (px < near_x) return 1'b1;
    sx = px - bx;
    sy = py - by;
    return (sx * ey < sy * ex);
  endfunction

  function automatic logic point_inside(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    int   prev;
    logic parity;
    if (poly_count < MIN_VERTICES) return 1'b0;
    if (px < bb_min_x || px > bb_max_x || py < bb_min_y || py > bb_max_y) return 1'b0;
    parity = 1'b0;
    prev   = poly_count - 1;
    for (int i = 0; i < poly_count; i++) begin
      parity ^= crosses_edge(px, py, poly_xs[prev], poly_ys[prev], poly_xs[i], poly_ys[i]);
      prev = i;
    end
    return parity;
  endfunction

  function automatic pip_outcome_t predict_outcome(pip_cmd_t c);
    pip_outcome_t r;
    r.in_poly = 1'b0;
    r.dropped = 1'b0;
    case (c.action)
      ACT_CLEAR: clear_geometry();
      ACT_APPEND: begin
        if (poly_count >= MAX_VERTICES) begin
          r.dropped = 1'b1;
        end else begin
          poly_xs[poly_count] = c.x;
          poly_ys[poly_count] = c.y;
          poly_count++;
          if (c.x < bb_min_x) bb_min_x = c.x;
          if (c.x > bb_max_x) bb_max_x = c.x;
          if (c.y < bb_min_y) bb_min_y = c.y;
          if (c.y > bb_max_y) bb_max_y = c.y;
        end
      end
      ACT_TEST: r.in_poly = point_inside(c.x, c.y);
      default: ;
    endcase
    r.count = COUNT_FIELD_W'(poly_count);
    return r;
  endfunction

  //--------------------------------------------------------------------------
  // Stimulus generation
  //--------------------------------------------------------------------------

  task automatic add_cmd(input logic [ACTION_W-1:0] act, input logic [COORD_BITS-1:0] x,
                         input logic [COORD_BITS-1:0] y, input bit hold_back);
    pip_cmd_t c;
    c.action = act;
    c.x      = x;
    c.y      = y;
    c.drain  = hold_back;
    cmd_queue.insert(cmd_queue.size(), c);
    n_queued++;
    if (act != ACT_NONE) n_planned++;
    if (act == ACT_CLEAR) begin
      plan_xs.delete();
      plan_ys.delete();
    end else if (act == ACT_APPEND && plan_xs.size() < MAX_VERTICES) begin
      plan_xs.insert(plan_xs.size(), x);
      plan_ys.insert(plan_ys.size(), y);
    end
  endtask

  function automatic logic [COORD_BITS-1:0] coord_between(logic [COORD_BITS-1:0] lo,
                                                          logic [COORD_BITS-1:0] hi);
    return COORD_BITS'($urandom_range(hi, lo));
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord();
    return COORD_BITS'($urandom);
  endfunction

  // Aim test points at vertices, edges, the box and its border, or anywhere
  task automatic pick_test_point(output logic [COORD_BITS-1:0] x,
                                 output logic [COORD_BITS-1:0] y);
    int n, i, j, kind;
    logic [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
    n    = plan_xs.size();
    kind = (n == 0) ? 6 : $urandom_range(0, 7);
    lo_x = COORD_MAX; lo_y = COORD_MAX; hi_x = '0; hi_y = '0;
    foreach (plan_xs[k]) begin
      if (plan_xs[k] < lo_x) lo_x = plan_xs[k];
      if (plan_xs[k] > hi_x) hi_x = plan_xs[k];
      if (plan_ys[k] < lo_y) lo_y = plan_ys[k];
      if (plan_ys[k] > hi_y) hi_y = plan_ys[k];
    end
    i = (n == 0) ? 0 : $urandom_range(0, n - 1);
    j = (n == 0) ? 0 : (i + 1) % n;
    case (kind)
      1: begin
        x = plan_xs[i]; y = plan_ys[i];
      end
      2: begin
        x = COORD_BITS'(({1'b0, plan_xs[i]} + {1'b0, plan_xs[j]}) >> 1);
        y = COORD_BITS'(({1'b0, plan_ys[i]} + {1'b0, plan_ys[j]}) >> 1);
      end
      3: begin
        x = coord_between(lo_x, hi_x); y = plan_ys[i];
      end
      4: begin
        x = plan_xs[i]; y = coord_between(lo_y, hi_y);
      end
      5: begin
        // just past the box border
        x = $urandom_range(0, 1) ? lo_x - 1'b1 : hi_x + 1'b1;
        y = coord_between(lo_y, hi_y);
        if ($urandom_range(0, 1)) begin
          x = coord_between(lo_x, hi_x);
          y = $urandom_range(0, 1) ? lo_y - 1'b1 : hi_y + 1'b1;
        end
      end
      6: begin
        x = rand_coord(); y = rand_coord();
      end
      default: begin
        x = coord_between(lo_x, hi_x); y = coord_between(lo_y, hi_y);
      end
    endcase
  endtask

  // Clear, load a polygon at some scale, then query it
  task automatic build_polygon();
    int n, tests, span, r;
    logic [COORD_BITS-1:0] base_x, base_y, x, y;
    add_cmd(ACT_CLEAR, rand_coord(), rand_coord(), $urandom_range(0, 59) == 0);
    case ($urandom_range(0, 3))
      0: span = 8;
      1: span = 256;
      2: span = 65536;
      default: span = 1 << COORD_BITS;
    endcase
    base_x = (span == (1 << COORD_BITS)) ? '0 : rand_coord();
    base_y = (span == (1 << COORD_BITS)) ? '0 : rand_coord();
    r = $urandom_range(0, 19);
    if (r == 0) n = $urandom_range(MAX_VERTICES - 4, MAX_VERTICES + 4);
    else if (r <= 2) n = $urandom_range(0, MIN_VERTICES - 1);
    else n = $urandom_range(MIN_VERTICES, 10);
    for (int k = 0; k < n; k++) begin
      add_cmd(ACT_APPEND, COORD_BITS'(base_x + $urandom_range(0, span - 1)),
              COORD_BITS'(base_y + $urandom_range(0, span - 1)), 1'b0);
    end
    tests = $urandom_range(1, 10);
    for (int k = 0; k < tests; k++) begin
      pick_test_point(x, y);
      add_cmd(ACT_TEST, x, y, 1'b0);
    end
  endtask

  // Stray requests of any code on whatever polygon is loaded
  task automatic add_noise();
    int n;
    n = $urandom_range(1, 4);
    for (int k = 0; k < n; k++) begin
      add_cmd(ACTION_W'($urandom_range(0, 3)), rand_coord(), rand_coord(), 1'b0);
    end
  endtask

  task automatic add_directed();
    // queries and stray code before any vertex, and while the square is built
    add_cmd(ACT_TEST, '0, '0, 1'b0);
    add_cmd(ACT_NONE, COORD_MAX, COORD_MAX, 1'b0);
    add_cmd(ACT_APPEND, '0, '0, 1'b0);
    add_cmd(ACT_TEST, '0, '0, 1'b0);
    add_cmd(ACT_APPEND, COORD_MAX, '0, 1'b0);
    add_cmd(ACT_TEST, COORD_MID, '0, 1'b0);
    add_cmd(ACT_APPEND, COORD_MAX, COORD_MAX, 1'b0);
    add_cmd(ACT_APPEND, '0, COORD_MAX, 1'b0);
    // full-range square: corners, border and center
    add_cmd(ACT_TEST, '0, '0, 1'b0);
    add_cmd(ACT_TEST, COORD_MID, COORD_MID, 1'b0);
    add_cmd(ACT_TEST, COORD_MAX, COORD_MAX, 1'b0);
    add_cmd(ACT_TEST, '0, COORD_MID, 1'b0);
    add_cmd(ACT_TEST, COORD_MAX, COORD_MID, 1'b0);
    add_cmd(ACT_TEST, COORD_MID, COORD_MAX, 1'b0);
    // small triangle with a horizontal base
    add_cmd(ACT_CLEAR, COORD_MAX, COORD_MAX, 1'b1);
    add_cmd(ACT_APPEND, 20'd10, 20'd10, 1'b0);
    add_cmd(ACT_APPEND, 20'd20, 20'd30, 1'b0);
    add_cmd(ACT_APPEND, 20'd30, 20'd10, 1'b0);
    add_cmd(ACT_TEST, 20'd20, 20'd20, 1'b0);
    add_cmd(ACT_TEST, 20'd10, 20'd20, 1'b0);
    add_cmd(ACT_TEST, 20'd25, 20'd10, 1'b0);
    add_cmd(ACT_TEST, 20'd20, 20'd30, 1'b0);
    add_cmd(ACT_TEST, 20'd11, 20'd11, 1'b0);
    add_cmd(ACT_CLEAR, '0, '0, 1'b0);
    add_cmd(ACT_TEST, 20'd20, 20'd20, 1'b0);
  endtask

  //--------------------------------------------------------------------------
  // Clock
  //--------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  //--------------------------------------------------------------------------
  // Request driver
  //--------------------------------------------------------------------------

  pip_cmd_t cur_cmd;
  int       gap_left;
  bit       sender_idle_on = 1'b1;

  always @(posedge clk_i) begin
    bit offer;
    if (!rst_ni) begin
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        outcome_queue.insert(outcome_queue.size(), predict_outcome(cur_cmd));
        n_accepted++;
        gap_left = sender_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if ($urandom_range(0, 39) == 0) sender_idle_on = !sender_idle_on;
      end
      // hold a request that was offered but not taken
      if (!(req_if.valid && !req_if.ready)) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() > 0 &&
                     !(cmd_queue[0].drain && outcome_queue.size() > 0)) begin
          cur_cmd        = cmd_queue.pop_front();
          offer          = 1'b1;
          req_if.action  <= cur_cmd.action;
          req_if.point_x <= cur_cmd.x;
          req_if.point_y <= cur_cmd.y;
        end
        req_if.valid <= offer;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Result monitor and checker
  //--------------------------------------------------------------------------

  int stall_left;
  bit receiver_idle_on = 1'b1;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("mismatch at result %0d: %s got %0d, want %0d", n_results, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    pip_outcome_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        n_results++;
        if (outcome_queue.size() == 0) begin
          report_mismatch("unexpected result, vertex_count", res_if.vertex_count, -1);
        end else begin
          want = outcome_queue.pop_front();
          if (res_if.inside_res !== want.in_poly)
            report_mismatch("inside_res", res_if.inside_res, want.in_poly);
          if (res_if.vertex_count !== want.count)
            report_mismatch("vertex_count", res_if.vertex_count, want.count);
          if (res_if.dropped !== want.dropped)
            report_mismatch("dropped", res_if.dropped, want.dropped);
        end
        stall_left = receiver_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        // long back-pressure so the block fills and stalls its input
        if (n_results == HOLD_AT_A || n_results == HOLD_AT_B) stall_left = LONG_HOLD;
        if ($urandom_range(0, 39) == 0) receiver_idle_on = !receiver_idle_on;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Watchdog on handshake progress
  //--------------------------------------------------------------------------

  int quiet_cycles;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Sequence: reset, stimulus, drain
  //--------------------------------------------------------------------------

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.action  = ACT_CLEAR;
    req_if.point_x = '0;
    req_if.point_y = '0;
    res_if.ready   = 1'b0;
    clear_geometry();

    add_directed();
    while (n_planned < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) add_noise();
      else build_polygon();
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_queued) @(posedge clk_i);
    while (outcome_queue.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (outcome_queue.size() != 0) begin
      $display("%0d expected results never arrived", outcome_queue.size());
    end
    if (mismatches == 0 && outcome_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
